@@ rtl/stq_pkg.sv @@
// shared constants, types and helpers of the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;

   localparam int MAX_TIMERS  = 16;
   localparam int MAX_RESULTS = 16;

   localparam int IDX_W  = $clog2(MAX_TIMERS);
   localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
   localparam int FIDX_W = $clog2(MAX_RESULTS);
   localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

   localparam int CMD_W    = 2;
   localparam int TIME_W   = 48;
   localparam int DUR_W    = 31;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
   localparam logic [ID_W-1:0] ID_LAST  = {ID_W{1'b1}};

   typedef enum logic [2:0] {
      RSP_REG_OK,
      RSP_FULL,
      RSP_UNREG_OK,
      RSP_NOT_FOUND,
      RSP_EMPTY,
      RSP_FIRE
   } rsp_kind_type;

   typedef struct packed {
      logic         accept;
      logic         insert;
      logic         id_adv;
      logic         unreg;
      logic         pop;
      logic         prep;
      logic         k_clr;
      logic         k_inc;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             slot_free;
      logic             full;
      logic             found;
      logic             head_due;
      logic             n_full;
      logic             n_zero;
      logic             k_at_n;
      logic             k_last;
      logic             reins_ok;
   } ctrl_sts_type;

   // time plus delay, clamped at the top of the time range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                 input logic [DUR_W-1:0]  d);
      logic [TIME_W:0] s;
      s = {1'b0, t} + {{(TIME_W + 1 - DUR_W){1'b0}}, d};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

@@ rtl/stq_dp.sv @@
// datapath: sorted timer list, fired buffer, request and result registers
`timescale 1ns / 1ps
module stq_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  stq_pkg::ctrl_cmd_type          cmd,
   output stq_pkg::ctrl_sts_type          sts,
   input  logic [stq_pkg::CMD_W-1:0]      req_command,
   input  logic [stq_pkg::TIME_W-1:0]     req_now_time,
   input  logic [stq_pkg::DUR_W-1:0]      req_duration,
   input  logic                           req_repeat_flag,
   input  logic [stq_pkg::ID_W-1:0]       req_cancel_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [stq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [stq_pkg::ID_W-1:0]       rsp_timer_id,
   output logic                           rsp_fired_valid,
   output logic                           rsp_pending,
   output logic                           rsp_last
);

   localparam int N = stq_pkg::MAX_TIMERS;

   // sorted list, head at index 0
   logic [stq_pkg::ID_W-1:0]   ent_id_ff  [N];
   logic [stq_pkg::TIME_W-1:0] ent_exp_ff [N];
   logic [stq_pkg::DUR_W-1:0]  ent_per_ff [N];
   logic                       ent_rep_ff [N];
   logic [stq_pkg::ID_W-1:0]   ent_id_in  [N];
   logic [stq_pkg::TIME_W-1:0] ent_exp_in [N];
   logic [stq_pkg::DUR_W-1:0]  ent_per_in [N];
   logic                       ent_rep_in [N];

   logic [stq_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [stq_pkg::ID_W-1:0]  next_id_ff;

   logic [stq_pkg::CMD_W-1:0]  op_ff;
   logic [stq_pkg::TIME_W-1:0] now_ff;
   logic [stq_pkg::ID_W-1:0]   cid_ff;

   // pending insertion
   logic [stq_pkg::ID_W-1:0]   ins_id_ff;
   logic [stq_pkg::TIME_W-1:0] ins_exp_ff;
   logic [stq_pkg::DUR_W-1:0]  ins_per_ff;
   logic                       ins_rep_ff;

   // timers fired by the current tick
   logic [stq_pkg::ID_W-1:0]  f_id_ff  [stq_pkg::MAX_RESULTS];
   logic [stq_pkg::DUR_W-1:0] f_per_ff [stq_pkg::MAX_RESULTS];
   logic                      f_rep_ff [stq_pkg::MAX_RESULTS];
   logic [stq_pkg::FCNT_W-1:0] n_ff;
   logic [stq_pkg::FCNT_W-1:0] k_ff;
   logic [stq_pkg::FIDX_W-1:0] k_idx;
   logic [stq_pkg::FIDX_W-1:0] n_idx;

   logic                         rsp_valid_ff;
   logic [stq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [stq_pkg::ID_W-1:0]     rsp_id_ff;
   logic                         rsp_fired_ff;
   logic                         rsp_pending_ff;
   logic                         rsp_last_ff;

   logic [N-1:0] live;
   logic [N-1:0] ge;
   logic [N-1:0] at_pos;
   logic [N-1:0] after_pos;
   logic [N-1:0] match;
   logic [N-1:0] seen;
   logic         found;
   logic         do_shift;

   assign k_idx = k_ff[stq_pkg::FIDX_W-1:0];
   assign n_idx = n_ff[stq_pkg::FIDX_W-1:0];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cmp
         assign live[g]  = (stq_pkg::CNT_W'(g) < cnt_ff);
         assign ge[g]    = live[g] && !(ins_exp_ff < ent_exp_ff[g]);
         assign match[g] = live[g] && (cid_ff != '0) && (ent_id_ff[g] == cid_ff);
         if (g == 0) begin : g_first
            assign at_pos[g] = !ge[g];
            assign seen[g]   = match[g] || cmd.pop;
         end else begin : g_rest
            assign at_pos[g] = !ge[g] && ge[g-1];
            assign seen[g]   = match[g] || seen[g-1];
         end
         assign after_pos[g] = !ge[g] && !at_pos[g];
      end
   endgenerate

   assign found    = |match;
   assign do_shift = cmd.pop || (cmd.unreg && found);

   generate
      for (g = 0; g < N; g++) begin : g_next
         always_comb begin
            ent_id_in[g]  = ent_id_ff[g];
            ent_exp_in[g] = ent_exp_ff[g];
            ent_per_in[g] = ent_per_ff[g];
            ent_rep_in[g] = ent_rep_ff[g];
            if (cmd.insert) begin
               if (at_pos[g]) begin
                  ent_id_in[g]  = ins_id_ff;
                  ent_exp_in[g] = ins_exp_ff;
                  ent_per_in[g] = ins_per_ff;
                  ent_rep_in[g] = ins_rep_ff;
               end else if (after_pos[g]) begin
                  ent_id_in[g]  = ent_id_ff[(g + N - 1) % N];
                  ent_exp_in[g] = ent_exp_ff[(g + N - 1) % N];
                  ent_per_in[g] = ent_per_ff[(g + N - 1) % N];
                  ent_rep_in[g] = ent_rep_ff[(g + N - 1) % N];
               end
            end else if (do_shift && seen[g] && (g < N - 1)) begin
               ent_id_in[g]  = ent_id_ff[(g + 1) % N];
               ent_exp_in[g] = ent_exp_ff[(g + 1) % N];
               ent_per_in[g] = ent_per_ff[(g + 1) % N];
               ent_rep_in[g] = ent_rep_ff[(g + 1) % N];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         ent_id_ff[i]  <= ent_id_in[i];
         ent_exp_ff[i] <= ent_exp_in[i];
         ent_per_ff[i] <= ent_per_in[i];
         ent_rep_ff[i] <= ent_rep_in[i];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.insert) begin
         cnt_in = cnt_ff + stq_pkg::CNT_W'(1);
      end else if (do_shift) begin
         cnt_in = cnt_ff - stq_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         next_id_ff <= stq_pkg::ID_FIRST;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.id_adv) begin
            next_id_ff <= (next_id_ff == stq_pkg::ID_LAST) ? stq_pkg::ID_FIRST
                                                           : next_id_ff + stq_pkg::ID_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff      <= req_command;
         now_ff     <= req_now_time;
         cid_ff     <= req_cancel_id;
         ins_id_ff  <= next_id_ff;
         ins_exp_ff <= stq_pkg::sat_add(req_now_time, req_duration);
         ins_per_ff <= req_duration;
         ins_rep_ff <= req_repeat_flag;
      end else if (cmd.prep) begin
         ins_id_ff  <= f_id_ff[k_idx];
         ins_exp_ff <= stq_pkg::sat_add(now_ff, f_per_ff[k_idx]);
         ins_per_ff <= f_per_ff[k_idx];
         ins_rep_ff <= 1'b1;
      end
      if (cmd.pop) begin
         f_id_ff[n_idx]  <= ent_id_ff[0];
         f_per_ff[n_idx] <= ent_per_ff[0];
         f_rep_ff[n_idx] <= ent_rep_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         k_ff <= '0;
      end else begin
         if (cmd.accept) begin
            n_ff <= '0;
         end else if (cmd.pop) begin
            n_ff <= n_ff + stq_pkg::FCNT_W'(1);
         end
         if (cmd.k_clr) begin
            k_ff <= '0;
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + stq_pkg::FCNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_pending_ff <= (cnt_in != '0);
         rsp_status_ff  <= stq_pkg::STATUS_OK;
         rsp_id_ff      <= '0;
         rsp_fired_ff   <= 1'b0;
         rsp_last_ff    <= 1'b1;
         case (cmd.rsp_kind)
            stq_pkg::RSP_REG_OK: begin
               rsp_id_ff <= next_id_ff;
            end
            stq_pkg::RSP_FULL: begin
               rsp_status_ff <= stq_pkg::STATUS_FULL;
            end
            stq_pkg::RSP_NOT_FOUND: begin
               rsp_status_ff <= stq_pkg::STATUS_NOT_FOUND;
            end
            stq_pkg::RSP_FIRE: begin
               rsp_id_ff    <= f_id_ff[k_idx];
               rsp_fired_ff <= 1'b1;
               rsp_last_ff  <= sts.k_last;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.slot_free = !rsp_valid_ff || rsp_ready;
      sts.full      = (cnt_ff >= stq_pkg::CNT_W'(N));
      sts.found     = found;
      sts.head_due  = (cnt_ff != '0) && (ent_exp_ff[0] <= now_ff);
      sts.n_full    = (n_ff == stq_pkg::FCNT_W'(stq_pkg::MAX_RESULTS));
      sts.n_zero    = (n_ff == '0);
      sts.k_at_n    = (k_ff == n_ff);
      sts.k_last    = (k_ff + stq_pkg::FCNT_W'(1) == n_ff);
      sts.reins_ok  = f_rep_ff[k_idx] && (cnt_ff < stq_pkg::CNT_W'(N));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_timer_id    = rsp_id_ff;
   assign rsp_fired_valid = rsp_fired_ff;
   assign rsp_pending     = rsp_pending_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ rtl/stq_ctrl.sv @@
// controller state machine of the sorted timer queue
`timescale 1ns / 1ps
module stq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stq_pkg::ctrl_sts_type sts,
   output stq_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_POP  = 6'b000100,
      ST_PREP = 6'b001000,
      ST_INS  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_kind = stq_pkg::RSP_EMPTY;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.op == stq_pkg::CMD_TICK) begin
               state_in = ST_POP;
            end else if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
               if (sts.op == stq_pkg::CMD_REGISTER) begin
                  if (sts.full) begin
                     cmd.rsp_kind = stq_pkg::RSP_FULL;
                  end else begin
                     cmd.insert   = 1'b1;
                     cmd.id_adv   = 1'b1;
                     cmd.rsp_kind = stq_pkg::RSP_REG_OK;
                  end
               end else if (sts.op == stq_pkg::CMD_UNREGISTER) begin
                  cmd.unreg    = 1'b1;
                  cmd.rsp_kind = sts.found ? stq_pkg::RSP_UNREG_OK : stq_pkg::RSP_NOT_FOUND;
               end
            end
         end
         ST_POP: begin
            if (sts.head_due && !sts.n_full) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.k_clr = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            // walk fired timers in order, putting periodic ones back
            if (sts.k_at_n) begin
               cmd.k_clr = 1'b1;
               state_in  = ST_EMIT;
            end else if (sts.reins_ok) begin
               cmd.prep = 1'b1;
               state_in = ST_INS;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         ST_INS: begin
            cmd.insert = 1'b1;
            cmd.k_inc  = 1'b1;
            state_in   = ST_PREP;
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               if (sts.n_zero) begin
                  cmd.rsp_kind = stq_pkg::RSP_EMPTY;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.rsp_kind = stq_pkg::RSP_FIRE;
                  cmd.k_inc    = 1'b1;
                  if (sts.k_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/sorted_timer_queue.sv @@
// Sorted timer queue: up to 16 one-shot or periodic timers kept in expiry order in a
// shifting register list. Items are handled one at a time. Register and unregister load
// their result in the execute state that follows the accept, once the result register is
// free. A tick pops due head entries one per cycle, up to 16 fired timers, then walks the
// fired timers and puts the periodic ones back, and then emits one result per fired timer
// (one empty result when nothing fires) through the single result register, which delivers
// one beat per cycle while the receiver is ready.
`timescale 1ns / 1ps
module sorted_timer_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [stq_pkg::CMD_W-1:0]    req_command,
   input  logic [stq_pkg::TIME_W-1:0]   req_now_time,
   input  logic [stq_pkg::DUR_W-1:0]    req_duration,
   input  logic                         req_repeat_flag,
   input  logic [stq_pkg::ID_W-1:0]     req_cancel_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [stq_pkg::STATUS_W-1:0] rsp_status,
   output logic [stq_pkg::ID_W-1:0]     rsp_timer_id,
   output logic                         rsp_fired_valid,
   output logic                         rsp_pending,
   output logic                         rsp_last
);

   stq_pkg::ctrl_cmd_type cmd;
   stq_pkg::ctrl_sts_type sts;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_now_time    (req_now_time),
      .req_duration    (req_duration),
      .req_repeat_flag (req_repeat_flag),
      .req_cancel_id   (req_cancel_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_timer_id    (rsp_timer_id),
      .rsp_fired_valid (rsp_fired_valid),
      .rsp_pending     (rsp_pending),
      .rsp_last        (rsp_last)
   );

endmodule
